// ----- sv/tksi_pkg.sv -----
package tksi_pkg;

  localparam int CAPACITY_DEF = 5;
  localparam int NAME_BYTES   = 15;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DUMP   = 1'b1
  } tksi_cmd_t;

  typedef struct packed {
    logic signed [31:0] score;
    logic [63:0]        name_lo;
    logic [55:0]        name_hi;
  } tksi_entry_t;

  // ins: insert step across the chain, rot: rotate one slot toward cell 0
  typedef struct packed {
    logic ins;
    logic rot;
  } tksi_ctrl_t;

  // Zero every name byte from the first zero byte onward.
  function automatic logic [8*NAME_BYTES-1:0] cut_name(input logic [8*NAME_BYTES-1:0] name);
    logic [8*NAME_BYTES-1:0] res;
    logic                    ended;
    res   = name;
    ended = 1'b0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (ended) begin
        res[8*b +: 8] = 8'h00;
      end else if (name[8*b +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

// ----- sv/tksi_cell.sv -----
module tksi_cell (
  input  logic                 clk,
  input  tksi_pkg::tksi_ctrl_t ctrl,
  input  logic                 in_range,
  input  tksi_pkg::tksi_entry_t new_entry,
  input  logic                 left_keep,
  input  tksi_pkg::tksi_entry_t left_entry,
  input  tksi_pkg::tksi_entry_t right_entry,
  output logic                 keep,
  output tksi_pkg::tksi_entry_t entry
);

  // Hold when this slot scores at least as well as the new word (older wins ties).
  assign keep = in_range && (entry.score >= new_entry.score);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!keep) begin
        entry <= left_keep ? new_entry : left_entry;
      end
    end else if (ctrl.rot) begin
      entry <= right_entry;
    end
  end

endmodule

// ----- sv/top_k_sorted_insert_unit.sv -----
// Sorted top-K table held in a chain of CAPACITY cells, best score in cell 0.
// In an insert, every cell compares its score with the new one at
// once and either holds, takes the new word, or takes its left neighbor's word.
// Its single result appears on the result ports in the cycle after start.
// A dump rotates the chain once around, one slot per cycle, and reports cell 0
// each cycle: CAPACITY results in a row, registered first into the dumping flag
// and then onto the result ports. busy is that dumping flag, so new starts are
// ignored until the last slot has rotated. result_strobe marks each
// result for exactly one cycle and the receiver cannot stall it, so it must
// take every result as it comes.
module top_k_sorted_insert_unit #(
  parameter int CAPACITY = tksi_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic signed [31:0] score,
  input  logic [63:0]        name_lo,
  input  logic [55:0]        name_hi,
  output logic               result_strobe,
  output logic               accepted,
  output logic [2:0]         rank,
  output logic [2:0]         entry_count,
  output logic [2:0]         slot_index,
  output logic               slot_valid,
  output logic signed [31:0] slot_score,
  output logic [63:0]        slot_name_lo,
  output logic [55:0]        slot_name_hi,
  output logic               last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  tksi_pkg::tksi_entry_t new_entry;
  tksi_pkg::tksi_entry_t q [CAPACITY];
  tksi_pkg::tksi_ctrl_t  ctrl;
  logic [CAPACITY-1:0]   keep;
  logic [CAPACITY-1:0]   in_range;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic                  dumping;
  logic [IW-1:0]         dump_idx;
  logic                  take;
  logic                  full;
  logic                  reject;
  logic [IW-1:0]         pos;
  logic                  dump_valid;

  assign busy = dumping;
  assign take = start && !busy;
  assign full = (count == CW'(CAPACITY));
  assign reject = full && keep[CAPACITY-1];

  always_comb begin
    logic [8*tksi_pkg::NAME_BYTES-1:0] nm;
    nm = tksi_pkg::cut_name({name_hi, name_lo});
    new_entry.score   = score;
    new_entry.name_lo = nm[63:0];
    new_entry.name_hi = nm[8*tksi_pkg::NAME_BYTES-1:64];
  end

  assign ctrl.ins = take && (cmd == tksi_pkg::CMD_INSERT) && !reject;
  assign ctrl.rot = dumping;

  always_comb begin
    count_next = count;
    if (ctrl.ins && !full) begin
      count_next = count + CW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign in_range[i] = (CW'(i) < count);
    tksi_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .in_range    (in_range[i]),
      .new_entry   (new_entry),
      .left_keep   ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i-1]),
      .left_entry  (q[(i == 0) ? 0 : i-1]),
      .right_entry (q[(i == CAPACITY-1) ? 0 : i+1]),
      .keep        (keep[i]),
      .entry       (q[i])
    );
  end

  // Slot where the new word lands: first cell that does not hold.
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!keep[i] && (i == 0 || keep[(i == 0) ? 0 : i-1])) begin
        pos = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      dumping  <= 1'b0;
      dump_idx <= '0;
    end else begin
      count <= count_next;
      if (take && (cmd == tksi_pkg::CMD_DUMP)) begin
        dumping  <= 1'b1;
        dump_idx <= '0;
      end else if (dumping) begin
        if (dump_idx == IW'(CAPACITY - 1)) begin
          dumping <= 1'b0;
        end
        dump_idx <= dump_idx + IW'(1);
      end
    end
  end

  assign dump_valid = ({1'b0, dump_idx} < (IW + 1)'(count));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (take && (cmd == tksi_pkg::CMD_INSERT)) || dumping;
    end
  end

  always_ff @(posedge clk) begin
    entry_count <= 3'(count_next);
    if (dumping) begin
      accepted     <= 1'b0;
      rank         <= '0;
      slot_index   <= 3'(dump_idx);
      slot_valid   <= dump_valid;
      slot_score   <= dump_valid ? q[0].score : '0;
      slot_name_lo <= dump_valid ? q[0].name_lo : '0;
      slot_name_hi <= dump_valid ? q[0].name_hi : '0;
      last         <= (dump_idx == IW'(CAPACITY - 1));
    end else begin
      accepted     <= !reject;
      rank         <= reject ? 3'd0 : 3'(pos);
      slot_index   <= '0;
      slot_valid   <= 1'b0;
      slot_score   <= '0;
      slot_name_lo <= '0;
      slot_name_hi <= '0;
      last         <= 1'b1;
    end
  end

endmodule
